// ===== rtl/fpso_pkg.sv =====
// fpso_pkg: shared constants, widths and codes of the segment locator
`timescale 1ns / 1ps

package fpso_pkg;

  localparam int unsigned MAX_SEGMENTS = 1024;
  localparam int unsigned IDX_W        = $clog2(MAX_SEGMENTS);
  localparam int unsigned CNT_W        = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned POS_W        = 42;
  localparam int unsigned SIZE_W       = 32;
  localparam int unsigned SEGNUM_W     = 11;
  localparam int unsigned OFF_W        = 32;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned STATUS_W     = 2;

  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [POS_W-1:0] pos_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR  = 2'd0,
    KIND_APPEND = 2'd1,
    KIND_QUERY  = 2'd2
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ORDER = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_WALK = 1'b1
  } state_e;

endpackage

// ===== rtl/fpso_ram.sv =====
// fpso_ram: prefix-sum table, one write and one registered read per cycle
`timescale 1ns / 1ps

module fpso_ram (
  input  logic          clk_i,
  input  logic          we_i,
  input  fpso_pkg::idx_t waddr_i,
  input  fpso_pkg::pos_t wdata_i,
  input  fpso_pkg::idx_t raddr_i,
  output fpso_pkg::pos_t rdata_o
);

  fpso_pkg::pos_t mem [fpso_pkg::MAX_SEGMENTS];
  fpso_pkg::pos_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/flat_position_to_segment_offset.sv =====
// flat_position_to_segment_offset: top level of the prefix-sum segment locator
`timescale 1ns / 1ps

// Takes one item when start is high and busy is low, and answers every item with
// exactly one result, shown for a single cycle with result_valid_o high; the
// receiver cannot stall, so it must take the result in that cycle. A clear, an
// append, an unused kind or a query that fails its range or order check answers
// in the cycle after it is taken, and busy stays low. A query that passes walks
// the prefix table, held in one synchronous memory with a registered read: the
// walk pointer moves forward one segment per step until the segment that holds
// the position is found; busy is high for the walk. Sorted queries keep the walk
// short on average. The table needs no clearing pass: only entries below the
// segment count are ever used.

module flat_position_to_segment_offset (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic [fpso_pkg::KIND_W-1:0]        kind_i,
  input  logic [fpso_pkg::SIZE_W-1:0]        segment_size_i,
  input  logic [fpso_pkg::POS_W-1:0]         position_i,
  output logic                               result_valid_o,
  output logic [fpso_pkg::SEGNUM_W-1:0]      segment_number_o,
  output logic [fpso_pkg::OFF_W-1:0]         offset_o,
  output logic [fpso_pkg::STATUS_W-1:0]      status_o
);

  fpso_pkg::state_e                  state_q, state_d;
  logic [fpso_pkg::CNT_W-1:0]        count_q, count_d;
  fpso_pkg::pos_t                    total_q, total_d;
  fpso_pkg::idx_t                    wp_q, wp_d;
  fpso_pkg::pos_t                    start_q, start_d;
  fpso_pkg::pos_t                    pos_q, pos_d;
  logic                              valid_q, valid_d;
  logic [fpso_pkg::SEGNUM_W-1:0]     seg_q, seg_d;
  logic [fpso_pkg::OFF_W-1:0]        off_q, off_d;
  fpso_pkg::status_e                 status_q, status_d;

  logic                              accept;
  logic                              we;
  fpso_pkg::idx_t                    raddr;
  fpso_pkg::pos_t                    rdata;
  fpso_pkg::pos_t                    sum;
  fpso_pkg::pos_t                    diff;
  logic                              advance;
  logic                              range_err;

  assign accept    = start && (state_q == fpso_pkg::S_IDLE);
  assign sum       = total_q + fpso_pkg::POS_W'(segment_size_i);
  assign diff      = pos_q - start_q;
  assign range_err = (position_i == '0) || (position_i > total_q) || (count_q == '0);
  assign advance   = (pos_q > rdata) &&
                     ((fpso_pkg::CNT_W'(wp_q) + fpso_pkg::CNT_W'(1)) < count_q);

  fpso_ram u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (count_q[fpso_pkg::IDX_W-1:0]),
    .wdata_i (sum),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      fpso_pkg::S_IDLE: begin
        if (accept && (kind_i == fpso_pkg::KIND_QUERY) && !range_err &&
            (position_i > start_q)) begin
          state_d = fpso_pkg::S_WALK;
        end
      end
      fpso_pkg::S_WALK: begin
        if (!advance) begin
          state_d = fpso_pkg::S_IDLE;
        end
      end
      default: state_d = fpso_pkg::S_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    count_d  = count_q;
    total_d  = total_q;
    wp_d     = wp_q;
    start_d  = start_q;
    pos_d    = pos_q;
    valid_d  = 1'b0;
    seg_d    = '0;
    off_d    = '0;
    status_d = fpso_pkg::ST_OK;
    we       = 1'b0;
    raddr    = wp_q;
    case (state_q)
      fpso_pkg::S_IDLE: begin
        if (accept) begin
          case (kind_i)
            fpso_pkg::KIND_CLEAR: begin
              valid_d = 1'b1;
              count_d = '0;
              total_d = '0;
              wp_d    = '0;
              start_d = '0;
            end
            fpso_pkg::KIND_APPEND: begin
              valid_d = 1'b1;
              if (count_q == fpso_pkg::CNT_W'(fpso_pkg::MAX_SEGMENTS)) begin
                status_d = fpso_pkg::ST_FULL;
              end else begin
                we      = 1'b1;
                total_d = sum;
                count_d = count_q + fpso_pkg::CNT_W'(1);
              end
            end
            fpso_pkg::KIND_QUERY: begin
              pos_d = position_i;
              if (range_err) begin
                valid_d  = 1'b1;
                status_d = fpso_pkg::ST_RANGE;
              end else if (position_i <= start_q) begin
                valid_d  = 1'b1;
                status_d = fpso_pkg::ST_ORDER;
              end
            end
            default: valid_d = 1'b1;
          endcase
        end
      end
      fpso_pkg::S_WALK: begin
        if (advance) begin
          start_d = rdata;
          wp_d    = wp_q + fpso_pkg::IDX_W'(1);
          raddr   = wp_q + fpso_pkg::IDX_W'(1);
        end else begin
          valid_d = 1'b1;
          seg_d   = fpso_pkg::SEGNUM_W'(wp_q) + fpso_pkg::SEGNUM_W'(1);
          off_d   = diff[fpso_pkg::OFF_W-1:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= fpso_pkg::S_IDLE;
      count_q  <= '0;
      total_q  <= '0;
      wp_q     <= '0;
      start_q  <= '0;
      valid_q  <= 1'b0;
      seg_q    <= '0;
      off_q    <= '0;
      status_q <= fpso_pkg::ST_OK;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      total_q  <= total_d;
      wp_q     <= wp_d;
      start_q  <= start_d;
      valid_q  <= valid_d;
      seg_q    <= seg_d;
      off_q    <= off_d;
      status_q <= status_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q <= pos_d;
  end

  assign busy             = (state_q == fpso_pkg::S_WALK);
  assign result_valid_o   = valid_q;
  assign segment_number_o = seg_q;
  assign offset_o         = off_q;
  assign status_o         = status_q;

endmodule

// ===== tb/flat_position_to_segment_offset_test.sv =====
// flat_position_to_segment_offset_test: self-checking testbench of the prefix-sum segment locator
`timescale 1ns / 1ps

module flat_position_to_segment_offset_test;
  import fpso_pkg::*;

  localparam int unsigned STALL_LIMIT = 20000;
  localparam int unsigned LONG_SEGMENTS = 150;
  localparam int unsigned PHASE_ITEMS = 130;
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct packed {
    logic [SEGNUM_W-1:0] seg;
    logic [OFF_W-1:0]    off;
    logic [STATUS_W-1:0] st;
  } located_t;

  class segment_locator_scoreboard;
    pos_t        prefix_sum [MAX_SEGMENTS];
    int unsigned seg_count;
    pos_t        total;
    int unsigned walk;
    located_t    pending [$];
    int unsigned errors;

    function new();
      seg_count = 0;
      total = '0;
      walk = 0;
      errors = 0;
    endfunction

    function pos_t seg_start(int unsigned idx);
      if (idx == 0) return '0;
      return prefix_sum[idx - 1];
    endfunction

    function pos_t walk_start();
      if (seg_count == 0) return '0;
      return seg_start(walk < seg_count ? walk : seg_count - 1);
    endfunction

    function void note_item(logic [KIND_W-1:0] kind, logic [SIZE_W-1:0] size, pos_t pos);
      located_t r;
      int unsigned p;
      r.seg = '0;
      r.off = '0;
      r.st = ST_OK;
      if (kind == KIND_CLEAR) begin
        seg_count = 0;
        total = '0;
        walk = 0;
      end else if (kind == KIND_APPEND) begin
        if (seg_count >= MAX_SEGMENTS) begin
          r.st = ST_FULL;
        end else begin
          total = total + size;
          prefix_sum[seg_count] = total;
          seg_count++;
        end
      end else if (kind == KIND_QUERY) begin
        p = walk;
        if (pos == '0 || pos > total || seg_count == 0) begin
          r.st = ST_RANGE;
        end else begin
          if (p >= seg_count) p = seg_count - 1;
          if (pos <= seg_start(p)) begin
            r.st = ST_ORDER;
          end else begin
            while (p + 1 < seg_count && pos > prefix_sum[p]) p++;
            walk = p;
            r.seg = SEGNUM_W'(p + 1);
            r.off = OFF_W'(pos - seg_start(p));
          end
        end
      end
      pending.insert(pending.size(), r);
    endfunction

    function void check_result(located_t got);
      located_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result seg %0d off %0d status %0d",
                 $time, got.seg, got.off, got.st);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.seg !== want.seg) begin
        $display("%0t: segment_number expected %0d got %0d", $time, want.seg, got.seg);
        errors++;
      end
      if (got.off !== want.off) begin
        $display("%0t: offset expected %0d got %0d", $time, want.off, got.off);
        errors++;
      end
      if (got.st !== want.st) begin
        $display("%0t: status expected %0d got %0d", $time, want.st, got.st);
        errors++;
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic [KIND_W-1:0]   kind_i;
  logic [SIZE_W-1:0]   segment_size_i;
  logic [POS_W-1:0]    position_i;
  logic                result_valid_o;
  logic [SEGNUM_W-1:0] segment_number_o;
  logic [OFF_W-1:0]    offset_o;
  logic [STATUS_W-1:0] status_o;

  segment_locator_scoreboard sb;
  int unsigned quiet_cycles;
  int unsigned items_sent;
  int unsigned idle_pct;
  int unsigned phase_pct [4] = '{0, 46, 0, 16};

  flat_position_to_segment_offset dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .kind_i           (kind_i),
    .segment_size_i   (segment_size_i),
    .position_i       (position_i),
    .result_valid_o   (result_valid_o),
    .segment_number_o (segment_number_o),
    .offset_o         (offset_o),
    .status_o         (status_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (result_valid_o === 1'b1) sb.check_result({segment_number_o, offset_o, status_o});
      if (start && busy === 1'b0) sb.note_item(kind_i, segment_size_i, position_i);
      if (result_valid_o === 1'b1 || (start && busy === 1'b0)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("flat_position_to_segment_offset_test: done, errors");
        $finish;
      end
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // called at a falling edge, returns at the falling edge after the item is taken
  task automatic send_item(logic [KIND_W-1:0] kind, logic [SIZE_W-1:0] size, pos_t pos);
    start <= 1'b1;
    kind_i <= kind;
    segment_size_i <= size;
    position_i <= pos;
    do @(posedge clk_i); while (busy !== 1'b0);
    @(negedge clk_i);
    items_sent++;
  endtask

  task automatic idle_cycle();
    start <= 1'b0;
    kind_i <= KIND_W'($urandom);
    segment_size_i <= $urandom;
    position_i <= POS_W'(rand64());
    @(negedge clk_i);
  endtask

  task automatic issue(logic [KIND_W-1:0] kind, logic [SIZE_W-1:0] size, pos_t pos);
    while ($urandom_range(99) < idle_pct) idle_cycle();
    send_item(kind, size, pos);
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 15) return '0;
    if (r < 70) return $urandom_range(1, 20);
    if (r < 85) return $urandom_range(21, 5000);
    if (r < 95) return $urandom;
    return '1;
  endfunction

  // mostly well-formed: often a clear, a run of appends, sorted queries with errors mixed in
  task automatic query_burst();
    int unsigned nseg;
    int unsigned nq;
    int unsigned r;
    logic [63:0] lo;
    logic [63:0] span;
    logic [63:0] pos;
    if ($urandom_range(9) < 8) issue(KIND_CLEAR, $urandom, POS_W'(rand64()));
    nseg = $urandom_range(1, 16);
    repeat (nseg) issue(KIND_APPEND, pick_size(), POS_W'(rand64()));
    nq = $urandom_range(1, 16);
    repeat (nq) begin
      r = $urandom_range(99);
      lo = 64'(sb.walk_start()) + 1;
      if (r < 72) begin
        if (sb.seg_count == 0 || lo > 64'(sb.total)) begin
          pos = rand64();
        end else begin
          span = ($urandom_range(99) < 20) ? 64'(sb.total) - lo + 1
                                           : (64'(sb.total) - lo) / 4 + 1;
          pos = lo + rand64() % span;
        end
        issue(KIND_QUERY, $urandom, POS_W'(pos));
      end else if (r < 80) begin
        case ($urandom_range(2))
          0: pos = 0;
          1: pos = 64'(sb.total) + 1 + $urandom_range(100);
          default: pos = rand64();
        endcase
        issue(KIND_QUERY, $urandom, POS_W'(pos));
      end else if (r < 88) begin
        pos = (lo > 1) ? rand64() % (lo - 1) + 1 : 0;
        issue(KIND_QUERY, $urandom, POS_W'(pos));
      end else if (r < 92) begin
        issue(KIND_APPEND, pick_size(), POS_W'(rand64()));
      end else if (r < 95) begin
        issue(KIND_UNUSED, $urandom, POS_W'(rand64()));
      end else begin
        issue(KIND_W'($urandom_range(3)), $urandom, POS_W'(rand64()));
      end
    end
  endtask

  // long table and a walk across all of it
  task automatic long_walk();
    int unsigned r;
    issue(KIND_CLEAR, '0, '0);
    repeat (LONG_SEGMENTS) begin
      r = $urandom_range(99);
      issue(KIND_APPEND, (r < 10) ? '0 : (r < 20) ? '1 : SIZE_W'($urandom), '0);
    end
    repeat (3) issue(KIND_APPEND, $urandom, POS_W'(rand64()));
    issue(KIND_QUERY, '0, sb.total);
    issue(KIND_QUERY, '0, pos_t'(1));
    issue(KIND_QUERY, '0, sb.total - 1);
    issue(KIND_CLEAR, '0, '0);
  endtask

  initial begin
    sb = new();
    rst_ni = 1'b0;
    start = 1'b0;
    kind_i = KIND_CLEAR;
    segment_size_i = '0;
    position_i = '0;
    quiet_cycles = 0;
    items_sent = 0;
    idle_pct = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    issue(KIND_CLEAR, '0, '0);
    issue(KIND_QUERY, '0, pos_t'(5));
    issue(KIND_APPEND, '0, '0);
    issue(KIND_APPEND, '1, '0);
    issue(KIND_APPEND, SIZE_W'(1), '0);
    issue(KIND_APPEND, '0, '0);
    issue(KIND_APPEND, SIZE_W'(7), '0);
    issue(KIND_QUERY, '0, '0);
    issue(KIND_QUERY, '0, pos_t'(1));
    issue(KIND_QUERY, '0, pos_t'(32'hFFFF_FFFF));
    issue(KIND_QUERY, '0, pos_t'(2));
    issue(KIND_QUERY, '0, 42'h1_0000_0000);
    issue(KIND_QUERY, '0, pos_t'(5));
    issue(KIND_QUERY, '0, 42'h1_0000_0001);
    issue(KIND_QUERY, '0, 42'h1_0000_0008);
    issue(KIND_UNUSED, '1, '1);
    issue(KIND_APPEND, SIZE_W'(3), '0);
    issue(KIND_QUERY, '0, 42'h1_0000_000A);
    issue(KIND_QUERY, '0, {POS_W{1'b1}});
    issue(KIND_CLEAR, '1, '1);
    issue(KIND_QUERY, '0, pos_t'(1));
    issue(KIND_APPEND, SIZE_W'(1), '0);
    issue(KIND_QUERY, '0, pos_t'(1));

    for (int ph = 0; ph < 4; ph++) begin
      int unsigned goal;
      idle_pct = phase_pct[ph];
      goal = items_sent + PHASE_ITEMS;
      while (items_sent < goal) query_burst();
      if (ph == 2) long_walk();
    end

    idle_cycle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("flat_position_to_segment_offset_test: done, clean");
    end else begin
      $display("flat_position_to_segment_offset_test: done, errors");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/fpso_pkg.sv
rtl/fpso_ram.sv
rtl/flat_position_to_segment_offset.sv
tb/flat_position_to_segment_offset_test.sv
